[src/cto_pkg.sv]
// ----------------------------------------------------------------------------
// cto_pkg
// Shared types and codes for the contact table with oldest-entry replacement.
// ----------------------------------------------------------------------------
package cto_pkg;

  typedef enum logic [1:0] {
    KIND_UPSERT = 2'd0,
    KIND_EXPIRE = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_UPDATED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_REPLACED = 3'd2,
    ST_DONE     = 3'd3,
    ST_READ_OK  = 3'd4,
    ST_READ_BAD = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_EX_RD,
    S_EX_CHK,
    S_EX_MRD,
    S_EX_MWR,
    S_RD_RD,
    S_RD_CAP,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [29:0] id;
    logic [31:0] stamp;
    logic [63:0] lat;
    logic [63:0] lon;
    logic [31:0] course;
    logic [31:0] speed;
    logic [59:0] lab_lo;
    logic [59:0] lab_hi;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

[src/cto_ram.sv]
// ----------------------------------------------------------------------------
// cto_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cto_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[src/contact_table_oldest_replace.sv]
// ----------------------------------------------------------------------------
// contact_table_oldest_replace
// Contact table keyed by id: upsert, expire, clear and read, one at a time.
// ----------------------------------------------------------------------------
// An upsert scans the stored entries, stopping early on a key match; an expire
// scans them and moves the last entry into each removed slot; a clear needs no
// RAM access; a read of an invalid index skips the data capture. No new item is
// taken until the result of the current one has been registered for output.
// Reset (synchronous, rst_n low) empties the table and restores the stale
// limit to 180000 ms; no clearing pass over the RAM is needed.
module contact_table_oldest_replace #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [29:0] in_contact_id,
  input  logic [31:0] in_time_ms,
  input  logic [63:0] in_latitude_word,
  input  logic [63:0] in_longitude_word,
  input  logic [31:0] in_course_word,
  input  logic [31:0] in_speed_word,
  input  logic [59:0] in_label_low,
  input  logic [59:0] in_label_high,
  input  logic [5:0]  in_read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [5:0]  out_slot,
  output logic [6:0]  out_entry_count,
  output logic [6:0]  out_removed_count,
  output logic [29:0] out_id,
  output logic [31:0] out_time,
  output logic [63:0] out_latitude,
  output logic [63:0] out_longitude,
  output logic [31:0] out_course,
  output logic [31:0] out_speed,
  output logic [59:0] out_label_low,
  output logic [59:0] out_label_high
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  cto_pkg::state_t  state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    i_r, i_nxt;
  logic [CW-1:0]    removed_r, removed_nxt;
  logic [IW-1:0]    old_r, old_nxt;
  logic [31:0]      old_stamp_r, old_stamp_nxt;
  logic [31:0]      stale_r;
  cto_pkg::kind_t   kind_r;
  logic [5:0]       idx_r;
  cto_pkg::entry_t  item_r;
  cto_pkg::status_t res_status_r, res_status_nxt;
  logic [5:0]       res_slot_r, res_slot_nxt;
  cto_pkg::entry_t  res_entry_r, res_entry_nxt;
  logic             out_valid_r;
  cto_pkg::entry_t  out_entry_r;
  cto_pkg::status_t out_status_r;
  logic [5:0]       out_slot_r;
  logic [CW-1:0]    out_count_r, out_removed_r;

  logic            ram_we;
  logic [IW-1:0]   ram_waddr, ram_raddr;
  cto_pkg::entry_t ram_wdata, ram_rdata;
  logic [cto_pkg::ENTRY_W-1:0] ram_rword;

  logic accept, fin_go, idx_ok, is_stale, keep_label;
  logic [31:0] age, stamp_diff;
  cto_pkg::entry_t new_entry;

  cto_ram #(
    .WIDTH (cto_pkg::ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rword)
  );

  assign ram_rdata  = cto_pkg::entry_t'(ram_rword);
  assign in_stall   = (state_r != cto_pkg::S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign fin_go     = !out_valid_r || !out_stall;
  assign idx_ok     = 32'(idx_r) < 32'(count_r);
  assign age        = item_r.stamp - ram_rdata.stamp;
  assign is_stale   = age > stale_r;
  assign stamp_diff = ram_rdata.stamp - old_stamp_r;
  assign keep_label = (item_r.lab_lo[5:0] == 6'd0) && (ram_rdata.lab_lo[5:0] != 6'd0);

  always_comb begin
    new_entry = item_r;
    if (keep_label) begin
      new_entry.lab_lo = ram_rdata.lab_lo;
      new_entry.lab_hi = ram_rdata.lab_hi;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cto_pkg::S_IDLE: begin
        if (accept) begin
          case (cto_pkg::kind_t'(in_kind))
            cto_pkg::KIND_UPSERT: state_nxt = cto_pkg::S_UP_RD;
            cto_pkg::KIND_EXPIRE: state_nxt = cto_pkg::S_EX_RD;
            cto_pkg::KIND_CLEAR:  state_nxt = cto_pkg::S_FIN;
            default:              state_nxt = cto_pkg::S_RD_RD;
          endcase
        end
      end
      cto_pkg::S_UP_RD:  state_nxt = (i_r == count_r) ? cto_pkg::S_FIN : cto_pkg::S_UP_CMP;
      cto_pkg::S_UP_CMP: begin
        state_nxt = (ram_rdata.id == item_r.id) ? cto_pkg::S_FIN : cto_pkg::S_UP_RD;
      end
      cto_pkg::S_EX_RD:  state_nxt = (i_r == count_r) ? cto_pkg::S_FIN : cto_pkg::S_EX_CHK;
      cto_pkg::S_EX_CHK: state_nxt = is_stale ? cto_pkg::S_EX_MRD : cto_pkg::S_EX_RD;
      cto_pkg::S_EX_MRD: state_nxt = cto_pkg::S_EX_MWR;
      cto_pkg::S_EX_MWR: state_nxt = cto_pkg::S_EX_RD;
      cto_pkg::S_RD_RD:  state_nxt = idx_ok ? cto_pkg::S_RD_CAP : cto_pkg::S_FIN;
      cto_pkg::S_RD_CAP: state_nxt = cto_pkg::S_FIN;
      cto_pkg::S_FIN:    state_nxt = fin_go ? cto_pkg::S_IDLE : cto_pkg::S_FIN;
      default:           state_nxt = cto_pkg::S_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    count_nxt      = count_r;
    i_nxt          = i_r;
    removed_nxt    = removed_r;
    old_nxt        = old_r;
    old_stamp_nxt  = old_stamp_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_entry_nxt  = res_entry_r;
    ram_we         = 1'b0;
    ram_waddr      = i_r[IW-1:0];
    ram_wdata      = item_r;
    ram_raddr      = i_r[IW-1:0];
    case (state_r)
      cto_pkg::S_IDLE: begin
        i_nxt          = '0;
        removed_nxt    = '0;
        res_slot_nxt   = '0;
        res_entry_nxt  = '0;
        res_status_nxt = cto_pkg::ST_DONE;
        if (accept && (cto_pkg::kind_t'(in_kind) == cto_pkg::KIND_CLEAR)) begin
          removed_nxt = count_r;
          count_nxt   = '0;
        end
      end
      cto_pkg::S_UP_RD: begin
        if (i_r == count_r) begin
          ram_we = 1'b1;
          if (32'(count_r) < ENTRIES) begin
            ram_waddr      = count_r[IW-1:0];
            res_slot_nxt   = 6'(count_r[IW-1:0]);
            res_status_nxt = cto_pkg::ST_INSERTED;
            count_nxt      = count_r + 1'b1;
          end else begin
            ram_waddr      = old_r;
            res_slot_nxt   = 6'(old_r);
            res_status_nxt = cto_pkg::ST_REPLACED;
          end
        end
      end
      cto_pkg::S_UP_CMP: begin
        if (ram_rdata.id == item_r.id) begin
          ram_we         = 1'b1;
          ram_wdata      = new_entry;
          res_slot_nxt   = 6'(i_r[IW-1:0]);
          res_status_nxt = cto_pkg::ST_UPDATED;
        end else begin
          // track first oldest stamp by wrapping signed difference
          if ((i_r == '0) || stamp_diff[31]) begin
            old_nxt       = i_r[IW-1:0];
            old_stamp_nxt = ram_rdata.stamp;
          end
          i_nxt = i_r + 1'b1;
        end
      end
      cto_pkg::S_EX_CHK: begin
        if (is_stale) begin
          count_nxt   = count_r - 1'b1;
          removed_nxt = removed_r + 1'b1;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      cto_pkg::S_EX_MRD: begin
        ram_raddr = count_r[IW-1:0];
      end
      cto_pkg::S_EX_MWR: begin
        // move last entry into the hole, then test this slot again
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      cto_pkg::S_RD_RD: begin
        ram_raddr      = IW'(idx_r);
        res_slot_nxt   = idx_r;
        res_status_nxt = idx_ok ? cto_pkg::ST_READ_OK : cto_pkg::ST_READ_BAD;
      end
      cto_pkg::S_RD_CAP: begin
        res_entry_nxt = ram_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cto_pkg::S_IDLE;
      count_r     <= '0;
      stale_r     <= 32'd180000;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_wr_en) begin
        stale_r <= cfg_wr_data;
      end
      if ((state_r == cto_pkg::S_FIN) && fin_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r          <= i_nxt;
    removed_r    <= removed_nxt;
    old_r        <= old_nxt;
    old_stamp_r  <= old_stamp_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_entry_r  <= res_entry_nxt;
    if (accept) begin
      kind_r        <= cto_pkg::kind_t'(in_kind);
      idx_r         <= in_read_index;
      item_r.id     <= in_contact_id;
      item_r.stamp  <= in_time_ms;
      item_r.lat    <= in_latitude_word;
      item_r.lon    <= in_longitude_word;
      item_r.course <= in_course_word;
      item_r.speed  <= in_speed_word;
      item_r.lab_lo <= in_label_low;
      item_r.lab_hi <= in_label_high;
    end
    if ((state_r == cto_pkg::S_FIN) && fin_go) begin
      out_status_r  <= res_status_r;
      out_slot_r    <= res_slot_r;
      out_count_r   <= count_r;
      out_removed_r <= (kind_r == cto_pkg::KIND_EXPIRE || kind_r == cto_pkg::KIND_CLEAR)
                       ? removed_r : '0;
      out_entry_r   <= res_entry_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_slot          = out_slot_r;
  assign out_entry_count   = 7'(out_count_r);
  assign out_removed_count = 7'(out_removed_r);
  assign out_id            = out_entry_r.id;
  assign out_time          = out_entry_r.stamp;
  assign out_latitude      = out_entry_r.lat;
  assign out_longitude     = out_entry_r.lon;
  assign out_course        = out_entry_r.course;
  assign out_speed         = out_entry_r.speed;
  assign out_label_low     = out_entry_r.lab_lo;
  assign out_label_high    = out_entry_r.lab_hi;

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the contact table: a directed table of operations,
// then phased random traffic with stale limit changes between phases, every
// result checked against a behavioral copy of the table or a fixed reply.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    cto_pkg::kind_t kind;
    logic [29:0] id;
    logic [31:0] stamp;
    logic [63:0] lat;
    logic [63:0] lon;
    logic [31:0] course;
    logic [31:0] speed;
    logic [59:0] lab_lo;
    logic [59:0] lab_hi;
    logic [5:0]  idx;
  } op_t;

  typedef struct {
    cto_pkg::status_t status;
    logic [5:0]  slot;
    logic [6:0]  count;
    logic [6:0]  removed;
    logic [29:0] id;
    logic [31:0] stamp;
    logic [63:0] lat;
    logic [63:0] lon;
    logic [31:0] course;
    logic [31:0] speed;
    logic [59:0] lab_lo;
    logic [59:0] lab_hi;
  } reply_t;

  typedef struct {
    op_t    op;
    bit     typed;
    reply_t want;
  } row_t;

  logic clk, rst_n;
  logic cfg_wr_en;
  logic [31:0] cfg_wr_data;
  logic in_valid, in_stall;
  logic [1:0] in_kind;
  logic [29:0] in_contact_id;
  logic [31:0] in_time_ms;
  logic [63:0] in_latitude_word, in_longitude_word;
  logic [31:0] in_course_word, in_speed_word;
  logic [59:0] in_label_low, in_label_high;
  logic [5:0] in_read_index;
  logic out_valid, out_stall;
  logic [2:0] out_status;
  logic [5:0] out_slot;
  logic [6:0] out_entry_count, out_removed_count;
  logic [29:0] out_id;
  logic [31:0] out_time;
  logic [63:0] out_latitude, out_longitude;
  logic [31:0] out_course, out_speed;
  logic [59:0] out_label_low, out_label_high;

  contact_table_oldest_replace uut (.*);

  // behavioral table
  cto_pkg::entry_t contacts [64];
  int unsigned live_count;
  logic [31:0] stale_ms;

  reply_t pending_replies[$];
  row_t   rows[$];
  int     fails;
  int     send_burst, recv_burst;
  logic [31:0] clock_ms;

  function automatic reply_t table_apply(op_t op);
    reply_t r;
    int unsigned i, old;
    logic [31:0] d;
    logic [59:0] keep_lo, keep_hi;
    bit found;
    cto_pkg::entry_t e;
    r = '{status: cto_pkg::ST_DONE, default: '0};
    e = '{id: op.id, stamp: op.stamp, lat: op.lat, lon: op.lon, course: op.course,
          speed: op.speed, lab_lo: op.lab_lo, lab_hi: op.lab_hi};
    case (op.kind)
      cto_pkg::KIND_UPSERT: begin
        found = 0;
        for (i = 0; i < live_count; i++) begin
          if (contacts[i].id == op.id) begin
            found = 1;
            break;
          end
        end
        if (found) begin
          keep_lo = contacts[i].lab_lo;
          keep_hi = contacts[i].lab_hi;
          contacts[i] = e;
          // empty new name keeps a stored one
          if (op.lab_lo[5:0] == 0 && keep_lo[5:0] != 0) begin
            contacts[i].lab_lo = keep_lo;
            contacts[i].lab_hi = keep_hi;
          end
          r.status = cto_pkg::ST_UPDATED;
          r.slot = 6'(i);
        end else if (live_count < 64) begin
          contacts[live_count] = e;
          r.slot = 6'(live_count);
          live_count++;
          r.status = cto_pkg::ST_INSERTED;
        end else begin
          old = 0;
          for (i = 1; i < live_count; i++) begin
            d = contacts[i].stamp - contacts[old].stamp;
            if (d[31]) old = i;
          end
          contacts[old] = e;
          r.status = cto_pkg::ST_REPLACED;
          r.slot = 6'(old);
        end
      end
      cto_pkg::KIND_EXPIRE: begin
        i = 0;
        while (i < live_count) begin
          d = op.stamp - contacts[i].stamp;
          if (d > stale_ms) begin
            live_count--;
            contacts[i] = contacts[live_count];
            r.removed++;
          end else begin
            i++;
          end
        end
      end
      cto_pkg::KIND_CLEAR: begin
        r.removed = 7'(live_count);
        live_count = 0;
      end
      default: begin
        r.slot = op.idx;
        if (op.idx < live_count) begin
          e = contacts[op.idx];
          r.status = cto_pkg::ST_READ_OK;
          r.id = e.id; r.stamp = e.stamp; r.lat = e.lat; r.lon = e.lon;
          r.course = e.course; r.speed = e.speed;
          r.lab_lo = e.lab_lo; r.lab_hi = e.lab_hi;
        end else begin
          r.status = cto_pkg::ST_READ_BAD;
        end
      end
    endcase
    r.count = 7'(live_count);
    return r;
  endfunction

  function automatic op_t make_op(cto_pkg::kind_t k, logic [29:0] id, logic [31:0] t,
                                  bit ones, logic [59:0] lab_lo, logic [5:0] idx);
    op_t o;
    o.kind = k; o.id = id; o.stamp = t; o.idx = idx;
    o.lat = ones ? '1 : '0; o.lon = ones ? '1 : '0;
    o.course = ones ? '1 : '0; o.speed = ones ? '1 : '0;
    o.lab_lo = lab_lo; o.lab_hi = ones ? '1 : '0;
    return o;
  endfunction

  function automatic op_t random_op();
    op_t o;
    int r;
    r = $urandom_range(0, 99);
    o.kind = r < 62 ? cto_pkg::KIND_UPSERT : r < 72 ? cto_pkg::KIND_EXPIRE :
             r < 74 ? cto_pkg::KIND_CLEAR : cto_pkg::KIND_READ;
    r = $urandom_range(0, 9);
    o.id = r < 7 ? 30'(32'd500000000 + $urandom_range(0, 79))
                 : 30'($urandom_range(0, 999999999));
    o.stamp = o.kind == cto_pkg::KIND_EXPIRE ? clock_ms : clock_ms - $urandom_range(0, 300000);
    o.lat = {$urandom, $urandom};
    o.lon = {$urandom, $urandom};
    o.course = $urandom;
    o.speed = $urandom;
    o.lab_lo = 60'({$urandom, $urandom});
    o.lab_hi = 60'({$urandom, $urandom});
    if ($urandom_range(0, 3) == 0) o.lab_lo[5:0] = '0;
    o.idx = 6'($urandom_range(0, 63));
    return o;
  endfunction

  task automatic add_row(op_t op, bit typed, reply_t want);
    rows.insert(rows.size(), '{op, typed, want});
  endtask

  task automatic send(op_t op, bit typed, reply_t want);
    int gap;
    reply_t r;
    if (send_burst > 0) begin
      send_burst--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 15);
      if ($urandom_range(0, 49) == 0) send_burst = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_kind <= op.kind;
    in_contact_id <= op.id;
    in_time_ms <= op.stamp;
    in_latitude_word <= op.lat;
    in_longitude_word <= op.lon;
    in_course_word <= op.course;
    in_speed_word <= op.speed;
    in_label_low <= op.lab_lo;
    in_label_high <= op.lab_hi;
    in_read_index <= op.idx;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    r = table_apply(op);
    pending_replies.insert(pending_replies.size(), typed ? want : r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_replies.size() > 0) @(posedge clk);
    // settle before the next phase
    repeat (300) @(posedge clk);
  endtask

  task automatic set_stale(logic [31:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    stale_ms = v;
  endtask

  task automatic chk(string f, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $error("%s: expected %0h, got %0h", f, e, a);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    reply_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        $error("result with none expected");
        fails++;
      end else begin
        w = pending_replies.pop_front();
        chk("status", 64'(w.status), 64'(out_status));
        chk("slot", 64'(w.slot), 64'(out_slot));
        chk("entry_count", 64'(w.count), 64'(out_entry_count));
        chk("removed_count", 64'(w.removed), 64'(out_removed_count));
        chk("out_id", 64'(w.id), 64'(out_id));
        chk("out_time", 64'(w.stamp), 64'(out_time));
        chk("out_latitude", w.lat, out_latitude);
        chk("out_longitude", w.lon, out_longitude);
        chk("out_course", 64'(w.course), 64'(out_course));
        chk("out_speed", 64'(w.speed), 64'(out_speed));
        chk("out_label_low", 64'(w.lab_lo), 64'(out_label_low));
        chk("out_label_high", 64'(w.lab_hi), 64'(out_label_high));
      end
    end
  end

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAIL contact_table_oldest_replace");
    $finish;
  end

  // result side: hold stall a random while, then take one transfer
  initial begin
    int n;
    out_stall = 1'b1;
    recv_burst = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (recv_burst > 0) begin
        recv_burst--;
        n = 0;
      end else begin
        n = $urandom_range(0, 15);
        if ($urandom_range(0, 49) == 0) recv_burst = $urandom_range(10, 40);
      end
      repeat (n) begin
        out_stall <= 1'b1;
        @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin
    reply_t z;
    logic [31:0] limits [5];
    op_t o;
    int p, k;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_kind = '0; in_contact_id = '0; in_time_ms = '0;
    in_latitude_word = '0; in_longitude_word = '0;
    in_course_word = '0; in_speed_word = '0;
    in_label_low = '0; in_label_high = '0; in_read_index = '0;
    fails = 0;
    send_burst = 0;
    live_count = 0;
    stale_ms = 32'd180000;
    clock_ms = 32'hFFF0_0000;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    z = '{status: cto_pkg::ST_DONE, default: '0};
    add_row(make_op(cto_pkg::KIND_READ, 0, 0, 0, 0, 0), 1,
            '{status: cto_pkg::ST_READ_BAD, default: '0});
    add_row(make_op(cto_pkg::KIND_READ, 0, 0, 1, '1, 63), 1,
            '{status: cto_pkg::ST_READ_BAD, slot: 63, default: '0});
    add_row(make_op(cto_pkg::KIND_CLEAR, 0, 0, 0, 0, 0), 1, z);
    add_row(make_op(cto_pkg::KIND_EXPIRE, 0, 32'hFFFFFFFF, 0, 0, 0), 1, z);
    add_row(make_op(cto_pkg::KIND_UPSERT, 0, 0, 0, 0, 0), 1,
            '{status: cto_pkg::ST_INSERTED, count: 1, default: '0});
    add_row(make_op(cto_pkg::KIND_UPSERT, '1, '1, 1, '1, '1), 1,
            '{status: cto_pkg::ST_INSERTED, slot: 1, count: 2, default: '0});
    add_row(make_op(cto_pkg::KIND_READ, 0, 0, 0, 0, 1), 0, z);
    // empty name on update keeps the stored name
    add_row(make_op(cto_pkg::KIND_UPSERT, '1, 32'h7FFFFFFF, 0, 60'hABC0, 0), 0, z);
    add_row(make_op(cto_pkg::KIND_READ, 0, 0, 0, 0, 1), 0, z);
    add_row(make_op(cto_pkg::KIND_UPSERT, 0, 5, 1, 60'h1, 0), 0, z);
    add_row(make_op(cto_pkg::KIND_UPSERT, 0, 6, 0, 60'h0, 0), 0, z);
    add_row(make_op(cto_pkg::KIND_READ, 0, 0, 0, 0, 0), 0, z);
    add_row(make_op(cto_pkg::KIND_UPSERT, 30'd7, 10, 0, 0, 0), 0, z);
    add_row(make_op(cto_pkg::KIND_UPSERT, 30'd7, 11, 1, 0, 0), 0, z);
    add_row(make_op(cto_pkg::KIND_READ, 0, 0, 0, 0, 2), 0, z);
    add_row(make_op(cto_pkg::KIND_READ, 0, 0, 0, 0, 3), 0, z);
    // wrapping age across zero
    add_row(make_op(cto_pkg::KIND_EXPIRE, 0, 32'h0002_0000, 0, 0, 0), 0, z);
    add_row(make_op(cto_pkg::KIND_EXPIRE, 0, 32'h8000_0000, 0, 0, 0), 0, z);
    add_row(make_op(cto_pkg::KIND_READ, 0, 0, 0, 0, 0), 0, z);
    add_row(make_op(cto_pkg::KIND_CLEAR, 0, 0, 0, 0, 0), 0, z);
    add_row(make_op(cto_pkg::KIND_READ, 0, 0, 0, 0, 0), 0, z);
    foreach (rows[i]) send(rows[i].op, rows[i].typed, rows[i].want);

    limits = '{32'd0, 32'hFFFFFFFF, 32'd1000, $urandom, 32'd180000};
    for (p = 0; p < 5; p++) begin
      set_stale(limits[p]);
      // fill past capacity so replacement of the oldest entry is exercised
      if (p != 1) begin
        send(make_op(cto_pkg::KIND_CLEAR, 0, 0, 0, 0, 0), 0, z);
        for (k = 0; k < 72; k++) begin
          o = random_op();
          o.kind = cto_pkg::KIND_UPSERT;
          o.id = 30'(100 * p + k);
          o.stamp = clock_ms + $urandom;
          send(o, 0, z);
        end
      end
      for (k = 0; k < 330; k++) begin
        clock_ms += ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 5000);
        if (p == 2 && k == 150) drain();
        send(random_op(), 0, z);
      end
    end

    drain();
    if (fails == 0) $display("PASS contact_table_oldest_replace");
    else $display("FAIL contact_table_oldest_replace");
    $finish;
  end
endmodule

[files.f]
src/cto_pkg.sv
src/cto_ram.sv
src/contact_table_oldest_replace.sv
tb/sv/tb.sv
